// File: rtl/srde_pkg.sv
// Shared types and constants of the sample rate drift estimator.
// Depends on nothing; used by srde_div and sample_rate_drift_estimator_unit.
package srde_pkg;

  localparam logic [1:0] CMD_INIT    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_UPDATE  = 2'd2;

  localparam logic REG_NOMINAL_RATE = 1'b0;
  localparam logic REG_INIT_RATIO   = 1'b1;

  localparam int unsigned K_W = 10;
  localparam logic [K_W-1:0] K_MS_PER_S    = 10'd1000;
  localparam logic [K_W-1:0] K_RATE_DECAY  = 10'd819;
  localparam logic [K_W-1:0] K_RATIO_GAIN  = 10'd332;
  localparam logic [31:0]    WINDOW_MS     = 32'd1000;

  localparam int unsigned DIV_W = 32;

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_DIV_MEAS  = 9'b000000010,
    ST_MUL_MEAS  = 9'b000000100,
    ST_DIV_INST  = 9'b000001000,
    ST_RATE_MUL  = 9'b000010000,
    ST_RATE_ADD  = 9'b000100000,
    ST_RATIO_MUL = 9'b001000000,
    ST_RATIO_ADD = 9'b010000000,
    ST_WRITE     = 9'b100000000
  } state_t;

endpackage

// File: rtl/srde_div.sv
// Radix-2 restoring divider for 32-bit unsigned operands, one quotient bit per cycle.
// Depends on srde_pkg for the operand width.
module srde_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [srde_pkg::DIV_W-1:0]   dividend,
  input  logic [srde_pkg::DIV_W-1:0]   divisor,
  output logic                         done,
  output logic [srde_pkg::DIV_W-1:0]   quotient
);

  localparam int unsigned CNT_W = $clog2(srde_pkg::DIV_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(srde_pkg::DIV_W - 1);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [srde_pkg::DIV_W-1:0]  rem;
  logic [srde_pkg::DIV_W-1:0]  quo;
  logic [srde_pkg::DIV_W-1:0]  dvs;
  logic [srde_pkg::DIV_W:0]    shifted;
  logic                        q_bit;
  logic [srde_pkg::DIV_W-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, quo[srde_pkg::DIV_W-1]};
    q_bit    = (shifted >= {1'b0, dvs});
    rem_next = q_bit ? srde_pkg::DIV_W'(shifted - {1'b0, dvs})
                     : shifted[srde_pkg::DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[srde_pkg::DIV_W-2:0], q_bit};
    end
  end

  assign quotient = quo;

endmodule

// File: rtl/sample_rate_drift_estimator_unit.sv
// Top level of the sample rate drift estimator: sequencer, state, shared multiplier.
// Depends on srde_pkg and srde_div.
// Init, restart, unused commands and updates that do not close the 1000 ms window go from
// accept to ST_WRITE, which loads their result into the output register when the output is
// free. An update that closes a window runs two 32-step divisions one after the other through
// the single shared divider, besides the handoffs, the three products of the shared constant
// multiplier, the two accumulations and the output load. The block accepts no beat while an
// item is in progress, but it takes the next beat while a finished result still waits in the
// output register; a result still stalled there holds the following item in its last cycle.
module sample_rate_drift_estimator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] now_ms,
  input  logic [15:0] samples,
  input  logic [16:0] playback_rate,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] ratio_q16
);

  srde_pkg::state_t state;
  logic [16:0] nominal_sample_rate;
  logic [15:0] initial_ratio_q15;
  logic [31:0] sample_count;
  logic [31:0] window_start;
  logic [31:0] rate_estimate_q8;
  logic [31:0] ratio_estimate_q16;
  logic [16:0] playback;
  logic [31:0] prod;

  logic        accept;
  logic [31:0] delta;
  logic        in_window;
  logic        div_start;
  logic [31:0] div_a;
  logic [31:0] div_b;
  logic        div_done;
  logic [31:0] quot;
  logic [31:0] mul_a;
  logic [srde_pkg::K_W-1:0] mul_k;
  logic [31:0] mul_p;
  logic        out_free;

  assign item_stall = (state != srde_pkg::ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign delta      = now_ms - window_start;
  assign in_window  = !delta[31] && (delta >= srde_pkg::WINDOW_MS);
  assign out_free   = !result_valid || !result_stall;

  assign div_start = (accept && (cmd == srde_pkg::CMD_UPDATE) && in_window)
                   || (state == srde_pkg::ST_MUL_MEAS);

  always_comb begin
    if (state == srde_pkg::ST_IDLE) begin
      div_a = {sample_count[16:0], 15'b0};
      div_b = delta;
    end else begin
      div_a = {rate_estimate_q8[24:0], 7'b0};
      div_b = {15'b0, playback};
    end
  end

  srde_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    case (state)
      srde_pkg::ST_MUL_MEAS: begin
        mul_a = quot;
        mul_k = srde_pkg::K_MS_PER_S;
      end
      srde_pkg::ST_RATE_MUL: begin
        mul_a = (prod >> 15) - (rate_estimate_q8 >> 8);
        mul_k = srde_pkg::K_RATE_DECAY;
      end
      default: begin
        mul_a = {quot[30:0], 1'b0} - ratio_estimate_q16;
        mul_k = srde_pkg::K_RATIO_GAIN;
      end
    endcase
    mul_p = mul_a * 32'(mul_k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= srde_pkg::ST_IDLE;
      result_valid        <= 1'b0;
      nominal_sample_rate <= 17'd48000;
      initial_ratio_q15   <= 16'd32768;
      sample_count        <= '0;
      window_start        <= '0;
      rate_estimate_q8    <= '0;
      ratio_estimate_q16  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          srde_pkg::REG_NOMINAL_RATE: nominal_sample_rate <= cfg_data;
          srde_pkg::REG_INIT_RATIO:   initial_ratio_q15   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if ((state == srde_pkg::ST_WRITE) && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        srde_pkg::ST_IDLE: begin
          if (accept) begin
            state <= srde_pkg::ST_WRITE;
            case (cmd)
              srde_pkg::CMD_INIT: begin
                sample_count       <= '0;
                window_start       <= now_ms;
                ratio_estimate_q16 <= {15'b0, initial_ratio_q15, 1'b0};
                rate_estimate_q8   <= {7'b0, nominal_sample_rate, 8'b0};
              end
              srde_pkg::CMD_RESTART: begin
                sample_count <= '0;
                window_start <= now_ms;
              end
              srde_pkg::CMD_UPDATE: begin
                if (in_window) begin
                  window_start <= now_ms;
                  sample_count <= {16'b0, samples};
                  state        <= srde_pkg::ST_DIV_MEAS;
                end else begin
                  sample_count <= sample_count + {16'b0, samples};
                end
              end
              default: ;
            endcase
          end
        end
        srde_pkg::ST_DIV_MEAS: begin
          if (div_done) begin
            state <= srde_pkg::ST_MUL_MEAS;
          end
        end
        srde_pkg::ST_MUL_MEAS: state <= srde_pkg::ST_DIV_INST;
        srde_pkg::ST_DIV_INST: begin
          if (div_done) begin
            state <= srde_pkg::ST_RATE_MUL;
          end
        end
        srde_pkg::ST_RATE_MUL: state <= srde_pkg::ST_RATE_ADD;
        srde_pkg::ST_RATE_ADD: begin
          rate_estimate_q8 <= rate_estimate_q8 + 32'($signed(prod) >>> 7);
          state            <= srde_pkg::ST_RATIO_MUL;
        end
        srde_pkg::ST_RATIO_MUL: state <= srde_pkg::ST_RATIO_ADD;
        srde_pkg::ST_RATIO_ADD: begin
          ratio_estimate_q16 <= ratio_estimate_q16 + 32'($signed(prod) >>> 8);
          state              <= srde_pkg::ST_WRITE;
        end
        srde_pkg::ST_WRITE: begin
          if (out_free) begin
            state <= srde_pkg::ST_IDLE;
          end
        end
        default: state <= srde_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      playback <= playback_rate;
    end
    if ((state == srde_pkg::ST_MUL_MEAS) || (state == srde_pkg::ST_RATE_MUL)
        || (state == srde_pkg::ST_RATIO_MUL)) begin
      prod <= mul_p;
    end
    if ((state == srde_pkg::ST_WRITE) && out_free) begin
      ratio_q16 <= ratio_estimate_q16;
    end
  end

endmodule

// File: rtl/srde_chk.sv
// Port-level checker for the sample rate drift estimator, with its bind statement.
// Depends on sample_rate_drift_estimator_unit; uses no package.
module srde_chk (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [31:0] ratio_q16
);

  // An accepted beat keeps the input side closed for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("input open right after an accepted beat");

  // A new result only appears when the previous cycle was still working on an item.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared without an item in progress");

  // A new result never appears while the input side is closed.
  a_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !item_stall)
    else $error("result appeared while an item was still in progress");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(ratio_q16)))
    else $error("stalled result changed");

endmodule

bind sample_rate_drift_estimator_unit srde_chk u_srde_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .ratio_q16    (ratio_q16)
);
